[design/stepd_pkg.sv]
package stepd_pkg;

    localparam int LEVEL_W   = 24;
    localparam int ACC_W     = 41;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ALPHA = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SWING    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WARMUP       = 3'd4;

    localparam logic [15:0]        ALPHA_RESET    = 16'd51118;
    localparam logic [LEVEL_W-1:0] DEAD_RESET     = 24'd22938;
    localparam logic [LEVEL_W-1:0] SWING_RESET    = 24'd55706;
    localparam logic [15:0]        INTERVAL_RESET = 16'd250;
    localparam logic [5:0]         WARMUP_RESET   = 6'd30;
    localparam logic [LEVEL_W-1:0] SMOOTH_RESET   = 24'd642908;

    // Unity in Q0.16, and the rounding constant of the filter.
    localparam logic [16:0]      ALPHA_ONE = 17'd65536;
    localparam logic [ACC_W-1:0] ROUND_HALF = 41'd32768;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ROOT_GO,
        ST_ROOT,
        ST_FILTER,
        ST_WRITE,
        ST_SCAN,
        ST_DRAIN,
        ST_THRESH,
        ST_DECIDE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic en;
        logic clr;
        logic bias;
    } mac_ctrl_t;

endpackage

[design/step_detector_dynamic_threshold.sv]
// Step detector with a sliding-window dynamic threshold.
//
// Samples enter on the s_ channel (valid/ready) and each request yields exactly
// one result on the m_ channel: the running step count, a flag that this sample
// counted a step, and the filtered acceleration magnitude in Q8.16. Configuration
// registers are to be written by the user through cfg_we/cfg_index/cfg_data only
// while the block is idle, which the block itself does not enforce; a write
// takes effect at the clock edge that carries it.
//
// A sample passes through one shared multiply-accumulate unit (three squares,
// then the two filter products), an iterative square root and a scan of the
// window memory at one entry per cycle, which its single read port sets. While
// detection is not yet running the result follows the write into the window;
// once it runs, the scan, threshold and decision come in between. A full window
// holds 50 entries by default. s_ready is high only while the sequencer is
// idle, so a request is not taken until the last one has been loaded into the
// output register, where results sit; when the receiver stalls the next request
// is still taken and worked on and waits only before its own result is loaded.
// After reset the filter holds 9.81 m/s^2, the window is empty and the count is
// zero; the window memory is not cleared: only written entries are ever scanned.
module step_detector_dynamic_threshold #(
    parameter int WINDOW_LEN = 50
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                cfg_we,
    input  logic [stepd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [stepd_pkg::CFG_DATA_W-1:0]    cfg_data,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_op,
    input  logic signed [15:0]                  s_accel_x,
    input  logic signed [15:0]                  s_accel_y,
    input  logic signed [15:0]                  s_accel_z,
    input  logic [31:0]                         s_time_ms,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [31:0]                         m_step_count,
    output logic                                m_step_seen,
    output logic [stepd_pkg::LEVEL_W-1:0]       m_filtered_level
);
    import stepd_pkg::*;

    localparam int AW = $clog2(WINDOW_LEN);
    localparam int FW = $clog2(WINDOW_LEN + 1);
    localparam int CW = (FW > 6) ? FW : 6;
    localparam logic [AW-1:0] LAST_POS = AW'(WINDOW_LEN - 1);
    localparam logic [FW-1:0] FULL     = FW'(WINDOW_LEN);

    // Sequencer and configuration state.
    state_t state_reg, state_next;
    logic [1:0] cnt_reg, cnt_next;

    logic [15:0]        alpha_reg, alpha_next;
    logic [LEVEL_W-1:0] dead_reg, dead_next;
    logic [LEVEL_W-1:0] swing_reg, swing_next;
    logic [15:0]        interval_reg, interval_next;
    logic [5:0]         warmup_reg, warmup_next;

    // Detector state.
    logic [LEVEL_W-1:0] smoothed_reg, smoothed_next;
    logic [AW-1:0]      wpos_reg, wpos_next;
    logic [FW-1:0]      fill_reg, fill_next;
    logic [31:0]        steps_reg, steps_next;
    logic [31:0]        last_reg, last_next;
    logic               above_reg, above_next;
    logic               m_valid_reg, m_valid_next;

    // Per-sample working registers.
    logic [15:0]        ax_reg, ax_next;
    logic [15:0]        ay_reg, ay_next;
    logic [15:0]        az_reg, az_next;
    logic [31:0]        time_reg, time_next;
    logic [AW-1:0]      scan_reg, scan_next;
    logic               dv_reg, dv_next;
    logic               first_reg, first_next;
    logic [LEVEL_W-1:0] mx_reg, mx_next;
    logic [LEVEL_W-1:0] mn_reg, mn_next;
    logic [LEVEL_W:0]   thr_reg, thr_next;
    logic               small_reg, small_next;
    logic               seen_reg, seen_next;

    logic [31:0]        out_count_reg, out_count_next;
    logic               out_seen_reg, out_seen_next;
    logic [LEVEL_W-1:0] out_level_reg, out_level_next;

    // Shared units.
    mac_ctrl_t          mac_ctrl;
    logic [16:0]        mac_a;
    logic [23:0]        mac_b;
    logic [ACC_W-1:0]   mac_acc;
    logic               root_start;
    logic               root_done;
    logic [15:0]        root_val;
    logic               ram_we;
    logic [LEVEL_W-1:0] ram_rdata;

    // Helpers.
    logic [15:0]        sq_sel;
    logic [FW-1:0]      fill_inc;
    logic               detect;
    logic               scan_last;
    logic               out_free;
    logic [LEVEL_W:0]   mid_sum;
    logic [31:0]        dt;

    function automatic logic [15:0] abs16(input logic [15:0] v);
        // The most negative input maps onto 32768, which still fits.
        abs16 = v[15] ? (~v + 16'd1) : v;
    endfunction

    stepd_mac u_mac (
        .aclk (aclk),
        .ctrl (mac_ctrl),
        .op_a (mac_a),
        .op_b (mac_b),
        .acc  (mac_acc)
    );

    stepd_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (root_start),
        .operand (mac_acc[31:0]),
        .done    (root_done),
        .root    (root_val)
    );

    stepd_ram #(
        .WIDTH (LEVEL_W),
        .DEPTH (WINDOW_LEN)
    ) u_window (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (wpos_reg),
        .wdata (mac_acc[39:16]),
        .raddr (scan_reg),
        .rdata (ram_rdata)
    );

    always_comb begin
        fill_inc  = (fill_reg < FULL) ? (fill_reg + FW'(1)) : fill_reg;
        detect    = CW'(fill_inc) >= CW'(warmup_reg);
        scan_last = FW'(scan_reg) == (fill_reg - FW'(1));
        out_free  = !m_valid_reg || m_ready;
        case (cnt_reg)
            2'd0:    sq_sel = ax_reg;
            2'd1:    sq_sel = ay_reg;
            default: sq_sel = az_reg;
        endcase
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = s_op ? ST_DONE : ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                if (cnt_reg == 2'd2) begin
                    state_next = ST_ROOT_GO;
                end
            end
            ST_ROOT_GO: state_next = ST_ROOT;
            ST_ROOT: begin
                if (root_done) begin
                    state_next = ST_FILTER;
                end
            end
            ST_FILTER: begin
                if (cnt_reg == 2'd1) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:  state_next = detect ? ST_SCAN : ST_DONE;
            ST_SCAN: begin
                if (scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:  state_next = ST_THRESH;
            ST_THRESH: state_next = ST_DECIDE;
            ST_DECIDE: state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb begin
        s_ready    = 1'b0;
        root_start = 1'b0;
        ram_we     = 1'b0;
        mac_ctrl   = '0;
        mac_a      = '0;
        mac_b      = '0;
        case (state_reg)
            ST_IDLE: s_ready = 1'b1;
            ST_SQUARE: begin
                mac_ctrl.en  = 1'b1;
                mac_ctrl.clr = (cnt_reg == 2'd0);
                mac_a        = {1'b0, sq_sel};
                mac_b        = {8'd0, sq_sel};
            end
            ST_ROOT_GO: root_start = 1'b1;
            ST_FILTER: begin
                // Old level weighted by alpha, new magnitude by one minus alpha.
                mac_ctrl.en   = 1'b1;
                mac_ctrl.clr  = (cnt_reg == 2'd0);
                mac_ctrl.bias = 1'b1;
                if (cnt_reg == 2'd0) begin
                    mac_a = {1'b0, alpha_reg};
                    mac_b = smoothed_reg;
                end else begin
                    mac_a = ALPHA_ONE - {1'b0, alpha_reg};
                    mac_b = {root_val, 8'd0};
                end
            end
            ST_WRITE: ram_we = 1'b1;
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // Datapath next values.
    always_comb begin
        cnt_next       = cnt_reg;
        alpha_next     = alpha_reg;
        dead_next      = dead_reg;
        swing_next     = swing_reg;
        interval_next  = interval_reg;
        warmup_next    = warmup_reg;
        smoothed_next  = smoothed_reg;
        wpos_next      = wpos_reg;
        fill_next      = fill_reg;
        steps_next     = steps_reg;
        last_next      = last_reg;
        above_next     = above_reg;
        ax_next        = ax_reg;
        ay_next        = ay_reg;
        az_next        = az_reg;
        time_next      = time_reg;
        scan_next      = scan_reg;
        dv_next        = (state_reg == ST_SCAN);
        first_next     = first_reg;
        mx_next        = mx_reg;
        mn_next        = mn_reg;
        thr_next       = thr_reg;
        small_next     = small_reg;
        seen_next      = seen_reg;
        out_count_next = out_count_reg;
        out_seen_next  = out_seen_reg;
        out_level_next = out_level_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        mid_sum        = {1'b0, mx_reg} + {1'b0, mn_reg};
        dt             = time_reg - last_reg;

        if (cfg_we) begin
            case (cfg_index)
                CFG_FILTER_ALPHA: alpha_next    = cfg_data[15:0];
                CFG_DEAD_ZONE:    dead_next     = cfg_data;
                CFG_MIN_SWING:    swing_next    = cfg_data;
                CFG_MIN_INTERVAL: interval_next = cfg_data[15:0];
                CFG_WARMUP:       warmup_next   = cfg_data[5:0];
                default:          alpha_next    = alpha_reg;
            endcase
        end

        // A window entry read in one cycle is folded into max and min in the next.
        if (dv_reg) begin
            first_next = 1'b0;
            if (first_reg || ram_rdata > mx_reg) begin
                mx_next = ram_rdata;
            end
            if (first_reg || ram_rdata < mn_reg) begin
                mn_next = ram_rdata;
            end
        end

        case (state_reg)
            ST_IDLE: begin
                cnt_next  = 2'd0;
                seen_next = 1'b0;
                ax_next   = abs16(s_accel_x);
                ay_next   = abs16(s_accel_y);
                az_next   = abs16(s_accel_z);
                time_next = s_time_ms;
                if (s_valid && s_op) begin
                    steps_next = '0;
                end
            end
            ST_SQUARE: cnt_next = (cnt_reg == 2'd2) ? 2'd0 : (cnt_reg + 2'd1);
            ST_FILTER: cnt_next = cnt_reg + 2'd1;
            ST_WRITE: begin
                smoothed_next = mac_acc[39:16];
                wpos_next     = (wpos_reg == LAST_POS) ? '0 : (wpos_reg + AW'(1));
                fill_next     = fill_inc;
                scan_next     = '0;
                first_next    = 1'b1;
            end
            ST_SCAN: begin
                if (!scan_last) begin
                    scan_next = scan_reg + AW'(1);
                end
            end
            ST_THRESH: begin
                small_next = (mx_reg - mn_reg) < swing_reg;
                thr_next   = {1'b0, mid_sum[LEVEL_W:1]} + {1'b0, dead_reg};
            end
            ST_DECIDE: begin
                if (small_reg) begin
                    above_next = 1'b0;
                end else begin
                    if ({1'b0, smoothed_reg} > thr_reg && !above_reg) begin
                        if (dt > {16'd0, interval_reg}) begin
                            steps_next = steps_reg + 32'd1;
                            last_next  = time_reg;
                            seen_next  = 1'b1;
                        end
                        above_next = 1'b1;
                    end
                    if ({1'b0, smoothed_reg} < thr_reg) begin
                        above_next = 1'b0;
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    out_count_next = steps_reg;
                    out_seen_next  = seen_reg;
                    out_level_next = smoothed_reg;
                end
            end
            default: begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            alpha_reg    <= ALPHA_RESET;
            dead_reg     <= DEAD_RESET;
            swing_reg    <= SWING_RESET;
            interval_reg <= INTERVAL_RESET;
            warmup_reg   <= WARMUP_RESET;
            smoothed_reg <= SMOOTH_RESET;
            wpos_reg     <= '0;
            fill_reg     <= '0;
            steps_reg    <= '0;
            last_reg     <= '0;
            above_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
            dv_reg       <= 1'b0;
        end else begin
            state_reg    <= state_next;
            alpha_reg    <= alpha_next;
            dead_reg     <= dead_next;
            swing_reg    <= swing_next;
            interval_reg <= interval_next;
            warmup_reg   <= warmup_next;
            smoothed_reg <= smoothed_next;
            wpos_reg     <= wpos_next;
            fill_reg     <= fill_next;
            steps_reg    <= steps_next;
            last_reg     <= last_next;
            above_reg    <= above_next;
            m_valid_reg  <= m_valid_next;
            dv_reg       <= dv_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg       <= cnt_next;
        ax_reg        <= ax_next;
        ay_reg        <= ay_next;
        az_reg        <= az_next;
        time_reg      <= time_next;
        scan_reg      <= scan_next;
        first_reg     <= first_next;
        mx_reg        <= mx_next;
        mn_reg        <= mn_next;
        thr_reg       <= thr_next;
        small_reg     <= small_next;
        seen_reg      <= seen_next;
        out_count_reg <= out_count_next;
        out_seen_reg  <= out_seen_next;
        out_level_reg <= out_level_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_step_count     = out_count_reg;
    assign m_step_seen      = out_seen_reg;
    assign m_filtered_level = out_level_reg;

endmodule

[design/stepd_ram.sv]
module stepd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 50
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[design/stepd_mac.sv]
module stepd_mac (
    input  logic                      aclk,
    input  stepd_pkg::mac_ctrl_t      ctrl,
    input  logic [16:0]               op_a,
    input  logic [23:0]               op_b,
    output logic [stepd_pkg::ACC_W-1:0] acc
);
    import stepd_pkg::*;

    logic [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0] acc_next;
    logic [ACC_W-1:0] base;
    logic [ACC_W-1:0] product;

    // The first term of a sum either starts from zero or from the rounding constant.
    always_comb begin
        product = ACC_W'(op_a) * ACC_W'(op_b);
        if (ctrl.clr) begin
            base = ctrl.bias ? ROUND_HALF : '0;
        end else begin
            base = acc_reg;
        end
        acc_next = ctrl.en ? (base + product) : acc_reg;
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

[design/stepd_sqrt.sv]
module stepd_sqrt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] operand,
    output logic        done,
    output logic [15:0] root
);
    import stepd_pkg::*;

    logic [31:0] rem_reg, rem_next;
    logic [31:0] root_reg, root_next;
    logic [31:0] bit_reg, bit_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;

    // One result bit per cycle, sixteen result bits for a 32-bit operand.
    always_comb begin
        rem_next  = rem_reg;
        root_next = root_reg;
        bit_next  = bit_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {1'b0, root_reg} + {1'b0, bit_reg};
        if (start) begin
            rem_next  = operand;
            root_next = '0;
            bit_next  = 32'h4000_0000;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if ({1'b0, rem_reg} >= trial) begin
                rem_next  = rem_reg - trial[31:0];
                root_next = (root_reg >> 1) + bit_reg;
            end else begin
                root_next = root_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg[0]) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
        bit_reg  <= bit_next;
    end

    assign done = done_reg;
    assign root = root_reg[15:0];

endmodule
